### hdl/branch_target_buffer_macros.svh
// Assertion macros for the branch target buffer.
`ifndef BRANCH_TARGET_BUFFER_MACROS_SVH
`define BRANCH_TARGET_BUFFER_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BTB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("btb assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BTB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("btb assertion failed");

`endif

### hdl/btb_pkg.sv
// Shared constants and types for the branch target buffer.
package btb_pkg;

    localparam int BTB_ENTRIES = 32;
    localparam int ADDR_W      = 64;

    localparam logic [ADDR_W-1:0] PC_STEP = ADDR_W'(4);

    localparam logic MODE_FETCH   = 1'b0;
    localparam logic MODE_RESOLVE = 1'b1;

    // Query travelling down the cell row.
    typedef struct packed {
        logic              vld;
        logic              mode;
        logic              taken;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] target;
        logic              hit;     // valid tag match seen upstream
        logic [ADDR_W-1:0] stored;  // target of that match, zero otherwise
        logic              tfound;  // any tag match seen upstream, valid or not
    } btb_probe_t;

    // Update broadcast from the controller to every cell.
    typedef struct packed {
        logic              ins_en;
        logic              inv_en;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] tgt;
    } btb_upd_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] ptarget;
        logic              mis;
        logic [ADDR_W-1:0] next_pc;
    } btb_result_t;

endpackage

### hdl/btb_cell.sv
// One buffer entry: holds tag, target and valid, and passes the query on.
module btb_cell
    import btb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  btb_probe_t probe_in,
    output btb_probe_t probe_out,
    input  btb_upd_t   upd,
    input  logic       ins_sel
);

    logic [ADDR_W-1:0] tag_reg, tag_next;
    logic [ADDR_W-1:0] tgt_reg, tgt_next;
    logic              valid_reg, valid_next;
    logic              cand_reg, cand_next;   // first tag match of the last query
    btb_probe_t        probe_reg, probe_next;
    logic              tag_eq;

    assign tag_eq = (tag_reg == probe_in.pc);

    always_comb begin
        probe_next = probe_in;
        if (probe_in.vld && !probe_in.hit && valid_reg && tag_eq) begin
            probe_next.hit    = 1'b1;
            probe_next.stored = tgt_reg;
        end
        if (tag_eq) begin
            probe_next.tfound = 1'b1;
        end
    end

    always_comb begin
        cand_next  = cand_reg;
        tag_next   = tag_reg;
        tgt_next   = tgt_reg;
        valid_next = valid_reg;
        if (probe_in.vld) begin
            cand_next = !probe_in.tfound && tag_eq;
        end
        if (upd.ins_en && ins_sel) begin
            tag_next   = upd.tag;
            tgt_next   = upd.tgt;
            valid_next = 1'b1;
        end else if (upd.inv_en && cand_reg) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg       <= '0;
            valid_reg     <= 1'b0;
            cand_reg      <= 1'b0;
            probe_reg.vld <= 1'b0;
        end else begin
            tag_reg   <= tag_next;
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
            probe_reg <= probe_next;
        end
    end

    // target is only read behind a set valid bit
    always_ff @(posedge aclk) begin
        tgt_reg <= tgt_next;
    end

    assign probe_out = probe_reg;

endmodule

### hdl/btb_chain.sv
// Row of buffer cells; a query walks one cell per clock.
module btb_chain
    import btb_pkg::*;
#(
    parameter int ENTRIES = BTB_ENTRIES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  btb_probe_t         probe_in,
    output btb_probe_t         probe_out,
    input  btb_upd_t           upd,
    input  logic [ENTRIES-1:0] ins_sel
);

    btb_probe_t probe_w [ENTRIES+1];

    assign probe_w[0] = probe_in;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        btb_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .probe_in  (probe_w[i]),
            .probe_out (probe_w[i+1]),
            .upd       (upd),
            .ins_sel   (ins_sel[i])
        );
    end

    assign probe_out = probe_w[ENTRIES];

endmodule

### hdl/branch_target_buffer.sv
// Fully associative branch target buffer with FIFO replacement: top level.
//
// Fully associative branch target buffer with FIFO replacement. Each input
// transfer is a fetch lookup (s_tuser = 0) or a branch resolve (s_tuser = 1).
// The entries sit in a row of ENTRIES cells; a query enters the first cell and
// moves one cell per clock, picking up the first valid tag match (hit, stored
// target) and the first tag match regardless of valid (the cell that a
// not-taken resolve clears). When the query leaves the last cell the
// controller forms the result, broadcasts any insert (slot chosen by the FIFO
// pointer) or invalidate to the cells, and parks the result in a pending
// register that feeds the output register. One item is in flight at a time:
// the next input is accepted only once the query has walked the cell row and
// its result has moved from the pending register into the output register. The
// output register lets the next item be accepted while a finished result
// still waits on m_tready. All entries reset to invalid with zero tags; there
// is no clearing pass.
module branch_target_buffer
    import btb_pkg::*;
#(
    parameter int ENTRIES = BTB_ENTRIES
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // pc[63:0], taken[64], target[128:65], zero pad
    input  logic         s_tuser,   // mode: 0 fetch lookup, 1 branch resolve
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // hit[0], predicted_target[64:1],
                                    // mispredict[65], next_pc[129:66], zero pad
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic              in_fire;
    logic [ADDR_W-1:0] in_pc;
    logic              in_taken;
    logic [ADDR_W-1:0] in_target;

    assign in_fire   = s_tvalid && s_tready;
    assign in_pc     = s_tdata[63:0];
    assign in_taken  = s_tdata[64];
    assign in_target = s_tdata[128:65];

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic              inflight_reg, inflight_next;  // query walking the cells
    logic              pend_vld_reg, pend_vld_next;
    btb_result_t       pend_reg, pend_next;
    logic              out_vld_reg, out_vld_next;
    btb_result_t       out_reg, out_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;            // FIFO insert slot
    logic              out_free;

    btb_probe_t        probe_in;
    btb_probe_t        probe_out;
    btb_upd_t          upd;
    logic [ENTRIES-1:0] ins_sel;
    btb_result_t       res;

    assign s_tready = !inflight_reg && !pend_vld_reg;
    assign out_free = !out_vld_reg || m_tready;

    // query launched into the first cell
    always_comb begin
        probe_in        = '0;
        probe_in.vld    = in_fire;
        probe_in.mode   = s_tuser;
        probe_in.taken  = in_taken;
        probe_in.pc     = in_pc;
        probe_in.target = in_target;
    end

    // one-hot slot select for inserts
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            ins_sel[i] = (ptr_reg == i[IDX_W-1:0]);
        end
    end

    btb_chain #(
        .ENTRIES (ENTRIES)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .probe_in  (probe_in),
        .probe_out (probe_out),
        .upd       (upd),
        .ins_sel   (ins_sel)
    );

    // ------------------------------------------------------------------
    // Result and buffer update when the query leaves the last cell
    // ------------------------------------------------------------------
    always_comb begin
        res         = '0;
        res.hit     = probe_out.hit;
        res.ptarget = probe_out.stored;
        upd         = '0;
        upd.tag     = probe_out.pc;
        upd.tgt     = probe_out.target;
        if (probe_out.mode == MODE_FETCH) begin
            res.next_pc = probe_out.hit ? probe_out.stored : probe_out.pc + PC_STEP;
        end else if (probe_out.taken) begin
            if (probe_out.hit) begin
                // taken hit counts as correct even with a stale target
                res.next_pc = probe_out.pc;
            end else begin
                res.mis     = 1'b1;
                res.next_pc = probe_out.target;
                upd.ins_en  = probe_out.vld && (probe_out.target < probe_out.pc);
            end
        end else begin
            if (probe_out.hit) begin
                res.mis     = 1'b1;
                res.next_pc = probe_out.pc + PC_STEP;
                upd.inv_en  = probe_out.vld;
            end else begin
                res.next_pc = probe_out.pc;
            end
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (upd.ins_en) begin
            ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Pending and output stages
    // ------------------------------------------------------------------
    always_comb begin
        inflight_next = inflight_reg;
        if (in_fire) begin
            inflight_next = 1'b1;
        end else if (probe_out.vld) begin
            inflight_next = 1'b0;
        end
    end

    always_comb begin
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        if (pend_vld_reg && out_free) begin
            out_vld_next  = 1'b1;
            out_next      = pend_reg;
            pend_vld_next = 1'b0;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
        if (probe_out.vld) begin
            pend_vld_next = 1'b1;
            pend_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            ptr_reg      <= '0;
        end else begin
            inflight_reg <= inflight_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            ptr_reg      <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_reg.next_pc, out_reg.mis, out_reg.ptarget, out_reg.hit};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "branch_target_buffer_macros.svh"

    // an accepted item drops s_tready right after acceptance
    `BTB_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, in_fire, !s_tready)
    // a query never leaves the row while an earlier result is still pending
    `BTB_ASSERT_IMP(a_no_pend_overwrite, aclk, aresetn, probe_out.vld, !pend_vld_reg && inflight_reg)
    // insert and invalidate never happen together
    `BTB_ASSERT_IMP(a_upd_exclusive, aclk, aresetn, upd.ins_en, !upd.inv_en)
    // a miss reports a zero predicted target
    `BTB_ASSERT_IMP(a_miss_zero_target, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[64:1] == '0)

endmodule

### tb/sv/branch_target_buffer_check.sv
`timescale 1ns / 1ps
// Result checker for the branch target buffer: shadow buffer, expected-result queue, compare.
module branch_target_buffer_check
    import btb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,   // pc[63:0], taken[64], target[128:65], zero pad
    input  logic         s_tuser,   // mode
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,   // hit[0], predicted_target[64:1],
                                    // mispredict[65], next_pc[129:66], zero pad
    output int           fail_count,
    output int           outstanding,
    output int           results_seen,
    output int           hits_seen,
    output int           flushes_seen,
    output int           inserts_done,
    output int           invalidates_done
);

    // shadow copy of the buffer contents
    logic [ADDR_W-1:0] slot_tag    [BTB_ENTRIES];
    logic [ADDR_W-1:0] slot_target [BTB_ENTRIES];
    logic              slot_valid  [BTB_ENTRIES];
    int unsigned       fill_slot;

    btb_result_t expected_results [$];

    int errors;
    int checked;
    int hits;
    int flushes;
    int inserts;
    int invalidates;

    // Works out the result of one transfer and applies its update to the shadow buffer.
    function automatic btb_result_t lookup_and_update(input logic mode,
                                                      input logic [ADDR_W-1:0] pc,
                                                      input logic taken,
                                                      input logic [ADDR_W-1:0] target);
        btb_result_t res;
        logic        matched;
        logic        cleared;
        res     = '0;
        matched = 1'b0;
        cleared = 1'b0;
        for (int i = 0; i < BTB_ENTRIES; i++) begin
            if (!matched && slot_valid[i] && slot_tag[i] == pc) begin
                matched     = 1'b1;
                res.ptarget = slot_target[i];
            end
        end
        res.hit = matched;
        if (mode == MODE_FETCH) begin
            res.next_pc = matched ? res.ptarget : pc + PC_STEP;
        end else if (taken) begin
            if (matched) begin
                res.next_pc = pc;
            end else begin
                res.mis     = 1'b1;
                res.next_pc = target;
                // only backward branches get an entry
                if (target < pc) begin
                    slot_tag[fill_slot]    = pc;
                    slot_target[fill_slot] = target;
                    slot_valid[fill_slot]  = 1'b1;
                    fill_slot              = (fill_slot + 1) % BTB_ENTRIES;
                    inserts++;
                end
            end
        end else if (matched) begin
            // first tag match wins here, valid or not
            for (int i = 0; i < BTB_ENTRIES; i++) begin
                if (!cleared && slot_tag[i] == pc) begin
                    slot_valid[i] = 1'b0;
                    cleared       = 1'b1;
                end
            end
            res.mis     = 1'b1;
            res.next_pc = pc + PC_STEP;
            invalidates++;
        end else begin
            res.next_pc = pc;
        end
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : score
        btb_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < BTB_ENTRIES; i++) begin
                slot_tag[i]    = '0;
                slot_target[i] = '0;
                slot_valid[i]  = 1'b0;
            end
            fill_slot = 0;
            expected_results.delete();
        end else begin
            // results first: an output transfer never belongs to this cycle's input
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result transfer with nothing expected, got %h",
                             $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.hit) hits++;
                    if (want.mis) flushes++;
                    compare_field("hit", ADDR_W'(want.hit), ADDR_W'(m_tdata[0]));
                    compare_field("predicted_target", want.ptarget, m_tdata[64:1]);
                    compare_field("mispredict", ADDR_W'(want.mis), ADDR_W'(m_tdata[65]));
                    compare_field("next_pc", want.next_pc, m_tdata[129:66]);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(lookup_and_update(s_tuser, s_tdata[63:0],
                                                             s_tdata[64], s_tdata[128:65]));
            end
        end
        fail_count       <= errors;
        outstanding      <= expected_results.size();
        results_seen     <= checked;
        hits_seen        <= hits;
        flushes_seen     <= flushes;
        inserts_done     <= inserts;
        invalidates_done <= invalidates;
    end

    initial begin
        errors      = 0;
        checked     = 0;
        hits        = 0;
        flushes     = 0;
        inserts     = 0;
        invalidates = 0;
        fill_slot   = 0;
    end

endmodule

### tb/sv/branch_target_buffer_test.sv
`timescale 1ns / 1ps
// Testbench top for the branch target buffer: clock, reset, stimulus, watchdog and verdict.
module branch_target_buffer_test;
    import btb_pkg::*;

    // One item walks the whole cell row plus pending and output stages.
    localparam int ITEM_CYCLES    = BTB_ENTRIES + 2;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Address pool is larger than the buffer so FIFO replacement wraps and evicts.
    localparam int POOL_SIZE      = 40;
    localparam int PHASE_ITEMS    = 90;

    typedef enum int {
        LOAD_STEADY,
        LOAD_SENDER_IDLE,
        LOAD_RECEIVER_STALL,
        LOAD_BOTH_IDLE,
        LOAD_FINAL_STEADY
    } load_phase_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata  = '0;    // pc[63:0], taken[64], target[128:65], zero pad
    logic         s_tuser  = 1'b0;  // mode: 0 fetch lookup, 1 branch resolve
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;          // hit[0], predicted_target[64:1],
                                    // mispredict[65], next_pc[129:66], zero pad

    int fail_count;
    int outstanding;
    int results_seen;
    int hits_seen;
    int flushes_seen;
    int inserts_done;
    int invalidates_done;

    // Sender pacing (only the stimulus process touches these).
    int send_idle_pct = 0;
    int long_gap_pct  = 0;
    // Receiver pacing, read by the m_tready driver, and the watchdog's quiet count.
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    logic [ADDR_W-1:0] branch_pool [POOL_SIZE];

    branch_target_buffer #(
        .ENTRIES (BTB_ENTRIES)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Passive checker: predicts every accepted input and scores every result.
    branch_target_buffer_check result_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .results_seen     (results_seen),
        .hits_seen        (hits_seen),
        .flushes_seen     (flushes_seen),
        .inserts_done     (inserts_done),
        .invalidates_done (invalidates_done)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver backpressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: any transfer on either channel resets the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("[branch_target_buffer] ERROR");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // Presents one item and holds it until the transfer happens. tvalid is only
    // lowered when an idle gap follows, so back-to-back items keep it high.
    task automatic send_item(input logic mode, input logic [ADDR_W-1:0] pc,
                             input logic taken, input logic [ADDR_W-1:0] target);
        int gap;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        // Occasional long gap so idle time also lands after the buffer is free again.
        if ($urandom_range(0, 99) < long_gap_pct) begin
            gap = $urandom_range(1, ITEM_CYCLES + 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, target, taken, pc};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly reused branch addresses so entries get hit, evicted, cleared and
    // re-inserted; taken resolves lean toward backward targets so they insert.
    task automatic send_random_item();
        logic              mode;
        logic              taken;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] target;
        int                pick;
        pc     = ($urandom_range(0, 99) < 75) ? branch_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : rand_addr();
        mode   = ($urandom_range(0, 99) < 40) ? MODE_FETCH : MODE_RESOLVE;
        taken  = ($urandom_range(0, 99) < 65);
        target = rand_addr();
        if (mode == MODE_RESOLVE && taken) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                target = pc - ADDR_W'($urandom_range(1, 65536));
            end else if (pick < 75) begin
                target = pc;
            end else if (pick < 85) begin
                target = pc + ADDR_W'($urandom_range(1, 4096));
            end
        end
        send_item(mode, pc, taken, target);
    endtask

    task automatic run_phase(input load_phase_t phase, input int items);
        case (phase)
            LOAD_SENDER_IDLE: begin
                send_idle_pct = 85;
                long_gap_pct  = 40;
                recv_stall_pct <= 0;
            end
            LOAD_RECEIVER_STALL: begin
                send_idle_pct = 0;
                long_gap_pct  = 0;
                recv_stall_pct <= 85;
            end
            LOAD_BOTH_IDLE: begin
                send_idle_pct = 31;
                long_gap_pct  = 20;
                recv_stall_pct <= 31;
            end
            default: begin
                send_idle_pct = 0;
                long_gap_pct  = 0;
                recv_stall_pct <= 0;
            end
        endcase
        repeat (items) send_random_item();
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            branch_pool[i] = rand_addr();
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, full speed ----
        // lookups and a not-taken resolve on an empty buffer, incl. pc+4 wrapping past the top
        send_item(MODE_FETCH,   '0, 1'b1, '1);
        send_item(MODE_FETCH,   '1, 1'b0, '0);
        send_item(MODE_RESOLVE, '0, 1'b0, '1);
        // taken miss, backward: inserts, then lookup hits with target zero
        send_item(MODE_RESOLVE, '1, 1'b1, '0);
        send_item(MODE_FETCH,   '1, 1'b0, '1);
        // taken hit with a different target still counts as correct
        send_item(MODE_RESOLVE, '1, 1'b1, 64'h5555_5555_5555_5555);
        // forward target and target equal to pc: redirect, no insert
        send_item(MODE_RESOLVE, 64'h1000, 1'b1, 64'h2000);
        send_item(MODE_FETCH,   64'h1000, 1'b0, '0);
        send_item(MODE_RESOLVE, 64'h1000, 1'b1, 64'h1000);
        send_item(MODE_FETCH,   64'h1000, 1'b1, '1);
        // not-taken hit clears the entry, next pc wraps
        send_item(MODE_RESOLVE, '1, 1'b0, '0);
        send_item(MODE_FETCH,   '1, 1'b0, '0);
        // re-insert the same tag into the next slot; the stale invalid slot with the
        // same tag comes first, so a not-taken hit clears that one and the new entry stays
        send_item(MODE_RESOLVE, '1, 1'b1, 64'hffff_ffff_ffff_fffe);
        send_item(MODE_RESOLVE, '1, 1'b0, 64'h1234);
        send_item(MODE_FETCH,   '1, 1'b0, '0);
        // alternating bit patterns
        send_item(MODE_RESOLVE, 64'h8000_0000_0000_0000, 1'b1, 64'h7fff_ffff_ffff_ffff);
        send_item(MODE_FETCH,   64'h8000_0000_0000_0000, 1'b0, '0);
        send_item(MODE_RESOLVE, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 64'h5555_5555_5555_5555);
        send_item(MODE_FETCH,   64'h5555_5555_5555_5555, 1'b1, '1);
        send_item(MODE_FETCH,   64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0);
        // not-taken hit then not-taken miss on the same pc
        send_item(MODE_RESOLVE, 64'h8000_0000_0000_0000, 1'b0, '1);
        send_item(MODE_RESOLVE, 64'h8000_0000_0000_0000, 1'b0, '0);

        // ---- random part under varying load ----
        run_phase(LOAD_STEADY,         PHASE_ITEMS);
        run_phase(LOAD_SENDER_IDLE,    PHASE_ITEMS);
        run_phase(LOAD_RECEIVER_STALL, PHASE_ITEMS);
        run_phase(LOAD_BOTH_IDLE,      PHASE_ITEMS);
        run_phase(LOAD_FINAL_STEADY,   PHASE_ITEMS);
        s_tvalid <= 1'b0;

        // drain: let the last transfer reach the checker's count, wait for every
        // expected result, then a quiet wait before the verdict
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (ITEM_CYCLES + 4) @(posedge aclk);

        $display("checked %0d results: %0d hits, %0d mispredicts", results_seen, hits_seen,
                 flushes_seen);
        $display("buffer saw %0d inserts and %0d invalidates across five load phases",
                 inserts_done, invalidates_done);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[branch_target_buffer] OK");
        end else begin
            $display("[branch_target_buffer] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/btb_pkg.sv
hdl/btb_cell.sv
hdl/btb_chain.sv
hdl/branch_target_buffer.sv
tb/sv/branch_target_buffer_check.sv
tb/sv/branch_target_buffer_test.sv
